[hw/rtl/sahal_pkg.sv]
// Package: constants and codes for the sensor average and alarm block.
package sahal_pkg;

  localparam int NCH = 4;

  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 10;
  localparam int PRES_W  = 14;
  localparam int LIGHT_W = 16;

  localparam int TEMP_OFS  = 0;
  localparam int HUM_OFS   = TEMP_OFS + TEMP_W;
  localparam int PRES_OFS  = HUM_OFS + HUM_W;
  localparam int LIGHT_OFS = PRES_OFS + PRES_W;
  localparam int ENTRY_W   = LIGHT_OFS + LIGHT_W;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ALARM_W   = 2;
  localparam int CHAN_W    = 3;
  localparam int AVG_W     = 18;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LIMITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_LIMITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LIMITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER_EN    = 3'd4;

  localparam logic [ALARM_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [ALARM_W-1:0] ST_HIGH   = 2'd1;
  localparam logic [ALARM_W-1:0] ST_LOW    = 2'd2;

  localparam logic [CFG_W-1:0] TEMP_LIMITS_RST  = 32'd24248540;
  localparam logic [CFG_W-1:0] HUM_LIMITS_RST   = 32'd45875600;
  localparam logic [CFG_W-1:0] PRES_LIMITS_RST  = 32'd688137500;
  localparam logic [CFG_W-1:0] LIGHT_LIMITS_RST = 32'd65536050;

  localparam int DEF_SAMPLE_DEPTH    = 10;
  localparam int DEF_ALARM_WINDOW_MS = 30000;
  localparam int DEF_TOGGLE_MS       = 250;
  localparam int DEF_CALM_PERIOD_MS  = 15000;
  localparam int DEF_CALM_BEEP_MS    = 50;

  function automatic logic signed [AVG_W-1:0] hyst_of(input logic [1:0] ch);
    logic signed [AVG_W-1:0] h;
    case (ch)
      2'd0:    h = 18'sd10;
      2'd1:    h = 18'sd50;
      2'd2:    h = 18'sd20;
      default: h = 18'sd50;
    endcase
    return h;
  endfunction

endpackage

[hw/rtl/sensor_average_hysteresis_alarm.sv]
// Top level: sample ring averaging, hysteresis alarms and buzzer timing.
// Each transaction is one millisecond tick. A tick without a sample goes straight to the finish
// state; a tick with a sample runs through one shared restoring divider that works through the
// four channel sums one quotient bit per cycle.
// The input is not ready while a tick is in work; a finished result waits in the output
// register and the next tick may be accepted meanwhile.
module sensor_average_hysteresis_alarm
  import sahal_pkg::*;
#(
  parameter int SAMPLE_DEPTH    = DEF_SAMPLE_DEPTH,
  parameter int ALARM_WINDOW_MS = DEF_ALARM_WINDOW_MS,
  parameter int TOGGLE_MS       = DEF_TOGGLE_MS,
  parameter int CALM_PERIOD_MS  = DEF_CALM_PERIOD_MS,
  parameter int CALM_BEEP_MS    = DEF_CALM_BEEP_MS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_sample_valid,
  input  logic signed [TEMP_W-1:0]  in_temp_reading,
  input  logic [HUM_W-1:0]          in_hum_reading,
  input  logic [PRES_W-1:0]         in_pres_reading,
  input  logic [LIGHT_W-1:0]        in_light_reading,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [TEMP_W-1:0]  out_temp_average,
  output logic [HUM_W-1:0]          out_hum_average,
  output logic [PRES_W-1:0]         out_pres_average,
  output logic [LIGHT_W-1:0]        out_light_average,
  output logic [ALARM_W-1:0]        out_temp_alarm,
  output logic [ALARM_W-1:0]        out_hum_alarm,
  output logic [ALARM_W-1:0]        out_pres_alarm,
  output logic [ALARM_W-1:0]        out_light_alarm,
  output logic [ALARM_W-1:0]        out_active_kind,
  output logic [CHAN_W-1:0]         out_active_channel,
  output logic                      out_global_alarm,
  output logic                      out_buzzer_drive
);

  localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = LIGHT_W + 2 + CNT_W;
  localparam int BIT_W  = $clog2(SUM_W);
  localparam int REM_W  = CNT_W + 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SAMPLE_DEPTH);
  localparam logic [31:0] WIN_MS  = 32'(ALARM_WINDOW_MS);
  localparam logic [31:0] TOG_MS  = 32'(TOGGLE_MS);
  localparam logic [31:0] PER_MS  = 32'(CALM_PERIOD_MS);
  localparam logic [31:0] BEEP_MS = 32'(CALM_BEEP_MS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ALARM = 3'd3;
  localparam logic [2:0] S_GLOB  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                state_r;
  logic [CFG_W-1:0]          lim_r [NCH];
  logic                      buz_en_r;
  logic [ENTRY_W-1:0]        ring_r [SAMPLE_DEPTH];
  logic [SLOT_W-1:0]         slot_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [SUM_W-1:0]   sum_r [NCH];
  logic signed [AVG_W-1:0]   avg_r [NCH];
  logic [ALARM_W-1:0]        alarm_r [NCH];
  logic                      prev_glob_r;
  logic [31:0]               now_r;
  logic [31:0]               start_r;
  logic [31:0]               tog_r;
  logic [31:0]               beep_r;
  logic                      buz_r;
  logic [1:0]                ch_r;
  logic [SUM_W-1:0]          num_r;
  logic                      neg_r;
  logic [REM_W-1:0]          rem_r;
  logic [SUM_W-1:0]          q_r;
  logic [BIT_W-1:0]          bit_r;

  logic                      o_valid_r;
  logic signed [TEMP_W-1:0]  o_temp_r;
  logic [HUM_W-1:0]          o_hum_r;
  logic [PRES_W-1:0]         o_pres_r;
  logic [LIGHT_W-1:0]        o_light_r;
  logic [ALARM_W-1:0]        o_alarm_r [NCH];
  logic [ALARM_W-1:0]        o_kind_r;
  logic [CHAN_W-1:0]         o_chan_r;
  logic                      o_glob_r;
  logic                      o_buz_r;

  logic                      in_acc;
  logic [ENTRY_W-1:0]        new_entry;
  logic signed [SUM_W-1:0]   new_f [NCH];
  logic signed [SUM_W-1:0]   old_f [NCH];
  logic signed [SUM_W-1:0]   cur_sum;
  logic [REM_W-1:0]          rem_sh;
  logic                      ge;
  logic [REM_W-1:0]          rem_nxt;
  logic [SUM_W-1:0]          q_nxt;
  logic signed [AVG_W-1:0]   avg_nxt;
  logic signed [AVG_W-1:0]   lo;
  logic signed [AVG_W-1:0]   hi;
  logic signed [AVG_W-1:0]   hyst;
  logic [ALARM_W-1:0]        alarm_nxt;
  logic                      any_alarm;
  logic [ALARM_W-1:0]        kind;
  logic [CHAN_W-1:0]         chan;
  logic                      buz_nxt;
  logic [31:0]               tog_nxt;
  logic [31:0]               beep_nxt;
  logic                      fin_go;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!o_valid_r || out_ready);

  assign new_entry = {in_light_reading, in_pres_reading, in_hum_reading, in_temp_reading};

  always_comb begin
    logic [ENTRY_W-1:0] old_e;
    old_e    = ring_r[slot_r];
    new_f[0] = SUM_W'(in_temp_reading);
    new_f[1] = SUM_W'(in_hum_reading);
    new_f[2] = SUM_W'(in_pres_reading);
    new_f[3] = SUM_W'(in_light_reading);
    old_f[0] = SUM_W'($signed(old_e[TEMP_OFS +: TEMP_W]));
    old_f[1] = SUM_W'(old_e[HUM_OFS +: HUM_W]);
    old_f[2] = SUM_W'(old_e[PRES_OFS +: PRES_W]);
    old_f[3] = SUM_W'(old_e[LIGHT_OFS +: LIGHT_W]);
  end

  assign cur_sum = sum_r[ch_r];
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[bit_r]};
  assign ge      = (rem_sh >= REM_W'(cnt_r));
  assign rem_nxt = ge ? (rem_sh - REM_W'(cnt_r)) : rem_sh;
  assign q_nxt   = {q_r[SUM_W-2:0], ge};

  always_comb begin
    logic [15:0] lo_h;
    logic [15:0] hi_h;
    lo_h    = lim_r[ch_r][15:0];
    hi_h    = lim_r[ch_r][31:16];
    avg_nxt = neg_r ? -AVG_W'(q_r) : AVG_W'(q_r);
    if (ch_r == 2'd0) begin
      lo = AVG_W'($signed(lo_h));
      hi = AVG_W'($signed(hi_h));
    end else begin
      lo = AVG_W'(lo_h);
      hi = AVG_W'(hi_h);
    end
    hyst      = hyst_of(ch_r);
    alarm_nxt = alarm_r[ch_r];
    if (avg_nxt < lo) begin
      alarm_nxt = ST_LOW;
    end else if (avg_nxt > hi) begin
      alarm_nxt = ST_HIGH;
    end else if (alarm_r[ch_r] == ST_LOW && avg_nxt > lo + hyst) begin
      alarm_nxt = ST_NORMAL;
    end else if (alarm_r[ch_r] == ST_HIGH && avg_nxt < hi - hyst) begin
      alarm_nxt = ST_NORMAL;
    end
  end

  always_comb begin
    any_alarm = 1'b0;
    kind      = ST_NORMAL;
    chan      = '0;
    for (int c = NCH - 1; c >= 0; c--) begin
      if (alarm_r[c] != ST_NORMAL) begin
        any_alarm = 1'b1;
        kind      = alarm_r[c];
        chan      = CHAN_W'(c + 1);
      end
    end
  end

  always_comb begin
    buz_nxt  = buz_r;
    tog_nxt  = tog_r;
    beep_nxt = beep_r;
    if (!buz_en_r) begin
      buz_nxt = 1'b0;
    end else if (any_alarm && (now_r - start_r) < WIN_MS) begin
      if ((now_r - tog_r) >= TOG_MS) begin
        tog_nxt = now_r;
        buz_nxt = !buz_r;
      end
    end else begin
      if ((now_r - beep_r) >= PER_MS) begin
        beep_nxt = now_r;
        buz_nxt  = 1'b1;
      end
      if (buz_nxt && (now_r - beep_nxt) >= BEEP_MS) begin
        buz_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lim_r[0]    <= TEMP_LIMITS_RST;
      lim_r[1]    <= HUM_LIMITS_RST;
      lim_r[2]    <= PRES_LIMITS_RST;
      lim_r[3]    <= LIGHT_LIMITS_RST;
      buz_en_r    <= 1'b1;
      for (int i = 0; i < SAMPLE_DEPTH; i++) ring_r[i] <= '0;
      for (int c = 0; c < NCH; c++) begin
        sum_r[c]   <= '0;
        avg_r[c]   <= '0;
        alarm_r[c] <= ST_NORMAL;
      end
      slot_r      <= '0;
      cnt_r       <= '0;
      prev_glob_r <= 1'b0;
      now_r       <= '0;
      start_r     <= '0;
      tog_r       <= '0;
      beep_r      <= '0;
      buz_r       <= 1'b0;
      ch_r        <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TEMP_LIMITS:  lim_r[0] <= cfg_wdata;
          REG_HUM_LIMITS:   lim_r[1] <= cfg_wdata;
          REG_PRES_LIMITS:  lim_r[2] <= cfg_wdata;
          REG_LIGHT_LIMITS: lim_r[3] <= cfg_wdata;
          REG_BUZZER_EN: begin
            buz_en_r <= cfg_wdata[0];
            buz_r    <= 1'b0;
          end
          default: ;
        endcase
      end
      if (o_valid_r && out_ready && !fin_go) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_sample_valid) begin
              ring_r[slot_r] <= new_entry;
              for (int c = 0; c < NCH; c++) sum_r[c] <= sum_r[c] - old_f[c] + new_f[c];
              slot_r  <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
              if (cnt_r != CNT_FULL) cnt_r <= cnt_r + 1'b1;
              ch_r    <= '0;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_LOAD: begin
          neg_r   <= cur_sum[SUM_W-1];
          num_r   <= cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
          rem_r   <= '0;
          q_r     <= '0;
          bit_r   <= BIT_W'(SUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          bit_r <= bit_r - 1'b1;
          if (bit_r == '0) state_r <= S_ALARM;
        end
        S_ALARM: begin
          avg_r[ch_r]   <= avg_nxt;
          alarm_r[ch_r] <= alarm_nxt;
          ch_r          <= ch_r + 1'b1;
          state_r       <= (ch_r == 2'(NCH - 1)) ? S_GLOB : S_LOAD;
        end
        S_GLOB: begin
          if (any_alarm && !prev_glob_r) start_r <= now_r;
          prev_glob_r <= any_alarm;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            buz_r     <= buz_nxt;
            tog_r     <= tog_nxt;
            beep_r    <= beep_nxt;
            now_r     <= now_r + 1'b1;
            o_valid_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      o_temp_r  <= avg_r[0][TEMP_W-1:0];
      o_hum_r   <= avg_r[1][HUM_W-1:0];
      o_pres_r  <= avg_r[2][PRES_W-1:0];
      o_light_r <= avg_r[3][LIGHT_W-1:0];
      for (int c = 0; c < NCH; c++) o_alarm_r[c] <= alarm_r[c];
      o_kind_r  <= kind;
      o_chan_r  <= chan;
      o_glob_r  <= any_alarm;
      o_buz_r   <= buz_nxt;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_temp_average   = o_temp_r;
  assign out_hum_average    = o_hum_r;
  assign out_pres_average   = o_pres_r;
  assign out_light_average  = o_light_r;
  assign out_temp_alarm     = o_alarm_r[0];
  assign out_hum_alarm      = o_alarm_r[1];
  assign out_pres_alarm     = o_alarm_r[2];
  assign out_light_alarm    = o_alarm_r[3];
  assign out_active_kind    = o_kind_r;
  assign out_active_channel = o_chan_r;
  assign out_global_alarm   = o_glob_r;
  assign out_buzzer_drive   = o_buz_r;

endmodule
